### design/fpma_pkg.sv
// Shared widths, register map and codes for the frame period monitor.
package fpma_pkg;

  // Fixed field widths
  localparam int TIME_W     = 32;
  localparam int WSIZE_W    = 7;
  localparam int RPT_SUM_W  = 38;
  localparam int CNT_W      = 32;

  // Configuration port
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int REG_IDX_W  = 2;

  // Default window depth for the period ring
  localparam int DEF_MAX_WINDOW = 64;

  // Register indexes (byte address is 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOW_RATE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 2'd3;

  // Register reset values
  localparam logic               RST_ENABLE   = 1'b0;
  localparam logic [WSIZE_W-1:0] RST_WINDOW   = 7'd15;
  localparam logic [TIME_W-1:0]  RST_LOW_RATE = 32'd33333;
  localparam logic [TIME_W-1:0]  RST_INTERVAL = 32'd10000000;

  // Item action codes
  localparam logic ACT_FRAME       = 1'b0;
  localparam logic ACT_LEVEL_START = 1'b1;

endpackage

### design/fpma_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module fpma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/frame_period_moving_average_monitor_unit.sv
// Pipeline: an accepted item is registered into the update stage (issue stage at acceptance),
//   and the update stage result is registered into the output register.
// Throughput: one item per cycle unless stalled; the ring RAM takes one read and one write
//   each cycle; a read that hits the entry being written is forwarded from the update stage.
// Reset: synchronous, clears registers, counters and the held frame; ring entries are marked
//   invalid at once by per-entry valid bits and read as zero, so no clearing pass is needed.
module frame_period_moving_average_monitor_unit #(
  parameter int MAX_WINDOW = fpma_pkg::DEF_MAX_WINDOW
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fpma_pkg::ADDR_W-1:0]      paddr,
  input  logic [fpma_pkg::DATA_W-1:0]      pwdata,
  output logic [fpma_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  // input items
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             action,
  input  logic [fpma_pkg::TIME_W-1:0]      timestamp,
  // result items
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             report_valid,
  output logic [fpma_pkg::RPT_SUM_W-1:0]   report_window_sum,
  output logic [fpma_pkg::CNT_W-1:0]       report_frame,
  output logic                             low_frame,
  output logic [fpma_pkg::CNT_W-1:0]       frame_total,
  output logic [fpma_pkg::TIME_W-1:0]      shortest_period,
  output logic [fpma_pkg::TIME_W-1:0]      longest_period
);

  import fpma_pkg::*;

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W = ($clog2(MAX_WINDOW + 1) > WSIZE_W) ? $clog2(MAX_WINDOW + 1) : WSIZE_W;
  localparam int SUM_W = TIME_W + WIN_W;

  // Configuration registers
  logic                 enable;
  logic [WSIZE_W-1:0]   window_size;
  logic [TIME_W-1:0]    low_rate_period;
  logic [TIME_W-1:0]    report_interval;

  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 cfg_write;
  logic                 win_clear;

  // Issue stage state
  logic [IDX_W-1:0]     ring_index;
  logic [IDX_W-1:0]     ring_index_next;
  logic [TIME_W-1:0]    previous_time;
  logic [MAX_WINDOW-1:0] entry_valid;

  // Update stage registers
  logic                 s1_valid;
  logic                 s1_action;
  logic [TIME_W-1:0]    s1_ts;
  logic [TIME_W-1:0]    s1_period;
  logic [IDX_W-1:0]     s1_idx;
  logic                 s1_fwd;
  logic [TIME_W-1:0]    s1_fwd_data;
  logic                 s1_entry_ok;

  // Monitor state
  logic [CNT_W-1:0]     frame_count,      frame_count_next;
  logic [TIME_W-1:0]    min_period,       min_period_next;
  logic [TIME_W-1:0]    max_period,       max_period_next;
  logic [TIME_W-1:0]    last_report_time, last_report_time_next;
  logic                 held_valid,       held_valid_next;
  logic [SUM_W-1:0]     held_sum,         held_sum_next;
  logic [CNT_W-1:0]     held_frame,       held_frame_next;
  logic [SUM_W-1:0]     window_sum,       window_sum_next;
  logic [SUM_W-1:0]     thresh;

  // Handshake and datapath
  logic                 s1_adv;
  logic                 accept;
  logic                 frame_go;
  logic                 lvl_go;
  logic                 s1_write;
  logic [WIN_W-1:0]     eff_w;
  logic [WIN_W-1:0]     ws_ext;
  logic [IDX_W-1:0]     idx_cur;
  logic [WIN_W-1:0]     idx_inc;
  logic [TIME_W-1:0]    period0;
  logic [TIME_W-1:0]    ram_rdata;
  logic [TIME_W-1:0]    old_period;
  logic [SUM_W-1:0]     sum_new;
  logic [SUM_W-1:0]     period_w;
  logic                 rpt_due;
  logic                 held_after;
  logic [SUM_W-1:0]     held_sum_after;
  logic                 low_hit;

  logic                 o_rep;
  logic [SUM_W-1:0]     o_sum;
  logic [CNT_W-1:0]     o_frame;
  logic                 o_low;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign win_clear = cfg_write && (cfg_idx == REG_WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= RST_ENABLE;
      window_size     <= RST_WINDOW;
      low_rate_period <= RST_LOW_RATE;
      report_interval <= RST_INTERVAL;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_ENABLE:   enable          <= pwdata[0];
        REG_WINDOW:   window_size     <= pwdata[WSIZE_W-1:0];
        REG_LOW_RATE: low_rate_period <= pwdata[TIME_W-1:0];
        REG_INTERVAL: report_interval <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE:   prdata = DATA_W'(enable);
      REG_WINDOW:   prdata = DATA_W'(window_size);
      REG_LOW_RATE: prdata = DATA_W'(low_rate_period);
      REG_INTERVAL: prdata = DATA_W'(report_interval);
      default:      prdata = '0;
    endcase
  end

  // Effective window: zero acts as one, clamp at the ring depth
  always_comb begin
    ws_ext = WIN_W'(window_size);
    if (ws_ext == '0) begin
      eff_w = WIN_W'(1);
    end else if (ws_ext > WIN_W'(MAX_WINDOW)) begin
      eff_w = WIN_W'(MAX_WINDOW);
    end else begin
      eff_w = ws_ext;
    end
  end

  // Low-rate threshold, refreshed every cycle from the registers
  always_ff @(posedge clk) begin
    thresh <= SUM_W'(eff_w) * SUM_W'(low_rate_period);
  end

  // ---------------- handshake ----------------
  assign s1_adv     = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign frame_go   = accept && (action == ACT_FRAME) && enable;
  assign lvl_go     = accept && (action == ACT_LEVEL_START);
  assign s1_write   = s1_adv && (s1_action == ACT_FRAME) && enable;

  // ---------------- issue stage ----------------
  assign idx_cur = (WIN_W'(ring_index) >= eff_w) ? '0 : ring_index;
  assign idx_inc = WIN_W'(idx_cur) + WIN_W'(1);
  assign ring_index_next = (idx_inc >= eff_w) ? '0 : idx_inc[IDX_W-1:0];
  assign period0 = timestamp - previous_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_index    <= '0;
      previous_time <= '0;
    end else if (win_clear) begin
      ring_index    <= '0;
    end else if (lvl_go) begin
      ring_index    <= '0;
      previous_time <= timestamp;
    end else if (frame_go) begin
      ring_index    <= ring_index_next;
      previous_time <= timestamp;
    end
  end

  // Entry valid bits; a clear wins over a write in the same cycle
  always_ff @(posedge clk) begin
    if (rst || win_clear || lvl_go) begin
      entry_valid <= '0;
    end else if (s1_write) begin
      entry_valid[s1_idx] <= 1'b1;
    end
  end

  // Period ring
  fpma_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (s1_write),
    .waddr (s1_idx),
    .wdata (s1_period),
    .re    (frame_go),
    .raddr (idx_cur),
    .rdata (ram_rdata)
  );

  // Update stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Update stage payload; forward a write landing on the entry being read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action   <= action;
      s1_ts       <= timestamp;
      s1_period   <= period0;
      s1_idx      <= idx_cur;
      s1_fwd      <= s1_write && (s1_idx == idx_cur);
      s1_fwd_data <= s1_period;
      s1_entry_ok <= entry_valid[idx_cur];
    end
  end

  // ---------------- update stage ----------------
  assign old_period     = s1_fwd ? s1_fwd_data : (s1_entry_ok ? ram_rdata : '0);
  assign sum_new        = window_sum - SUM_W'(old_period) + SUM_W'(s1_period);
  assign rpt_due        = held_valid && ((s1_ts - last_report_time) > report_interval);
  assign held_after     = held_valid && !rpt_due;
  assign held_sum_after = rpt_due ? '0 : held_sum;
  assign period_w       = SUM_W'(s1_period) * SUM_W'(eff_w);
  assign low_hit        = (sum_new >= thresh) && (!held_after || (period_w >= held_sum_after));

  always_comb begin
    frame_count_next      = frame_count;
    min_period_next       = min_period;
    max_period_next       = max_period;
    last_report_time_next = last_report_time;
    held_valid_next       = held_valid;
    held_sum_next         = held_sum;
    held_frame_next       = held_frame;
    window_sum_next       = window_sum;
    o_rep                 = 1'b0;
    o_sum                 = '0;
    o_frame               = '0;
    o_low                 = 1'b0;

    if (s1_action == ACT_LEVEL_START) begin
      // level start: back to the reset picture, report clock restarts here
      frame_count_next      = '0;
      min_period_next       = '1;
      max_period_next       = '0;
      last_report_time_next = s1_ts;
      held_valid_next       = 1'b0;
      held_sum_next         = '0;
      held_frame_next       = '0;
      window_sum_next       = '0;
    end else if (enable) begin
      frame_count_next = frame_count + CNT_W'(1);
      if (s1_period > max_period) begin
        max_period_next = s1_period;
      end
      if (s1_period < min_period) begin
        min_period_next = s1_period;
      end

      // report the held frame before this frame enters the window
      if (rpt_due) begin
        o_rep                 = 1'b1;
        o_sum                 = held_sum;
        o_frame               = held_frame;
        last_report_time_next = s1_ts;
      end
      held_valid_next = held_after;
      held_sum_next   = held_sum_after;
      held_frame_next = rpt_due ? '0 : held_frame;

      window_sum_next = sum_new;

      if (low_hit) begin
        held_valid_next = 1'b1;
        held_sum_next   = sum_new;
        held_frame_next = frame_count_next;
        o_low           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count      <= '0;
      min_period       <= '1;
      max_period       <= '0;
      last_report_time <= '0;
      held_valid       <= 1'b0;
      held_sum         <= '0;
      held_frame       <= '0;
      window_sum       <= '0;
    end else begin
      if (s1_adv) begin
        frame_count      <= frame_count_next;
        min_period       <= min_period_next;
        max_period       <= max_period_next;
        last_report_time <= last_report_time_next;
        held_valid       <= held_valid_next;
        held_sum         <= held_sum_next;
        held_frame       <= held_frame_next;
        window_sum       <= window_sum_next;
      end
      if (win_clear) begin
        window_sum <= '0;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      report_valid      <= o_rep;
      report_window_sum <= o_sum[RPT_SUM_W-1:0];
      report_frame      <= o_frame;
      low_frame         <= o_low;
      frame_total       <= frame_count_next;
      shortest_period   <= min_period_next;
      longest_period    <= max_period_next;
    end
  end

endmodule

### design/fpma_checker.sv
// Port-level checks for the frame period monitor, bound to the top level.
module fpma_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             result_valid,
  input logic                             result_stall,
  input logic                             report_valid,
  input logic [fpma_pkg::RPT_SUM_W-1:0]   report_window_sum,
  input logic [fpma_pkg::CNT_W-1:0]       report_frame,
  input logic                             low_frame,
  input logic [fpma_pkg::CNT_W-1:0]       frame_total,
  input logic [fpma_pkg::TIME_W-1:0]      shortest_period,
  input logic [fpma_pkg::TIME_W-1:0]      longest_period
);

  import fpma_pkg::*;

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result shown right after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid &&
      $stable({report_valid, report_window_sum, report_frame, low_frame,
               frame_total, shortest_period, longest_period}))
    else $error("stalled result changed");

  // Report fields are zero when nothing is reported
  a_no_report_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !report_valid |-> report_window_sum == '0 && report_frame == '0)
    else $error("report fields set without a report");

  // Extremes are either untouched or ordered
  a_extremes: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (shortest_period == '1 && longest_period == '0) ||
                     (longest_period >= shortest_period))
    else $error("shortest period above longest period");

endmodule

bind frame_period_moving_average_monitor_unit fpma_checker u_fpma_checker (.*);

### dv/frame_period_moving_average_monitor_unit_test.sv
// Self-checking testbench for the frame period moving average monitor.
module frame_period_moving_average_monitor_unit_test;
  import fpma_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;

  // One result item as seen on the output side
  typedef struct packed {
    logic                 rv;
    logic [RPT_SUM_W-1:0] rsum;
    logic [CNT_W-1:0]     rframe;
    logic                 low;
    logic [CNT_W-1:0]     total;
    logic [TIME_W-1:0]    shortest;
    logic [TIME_W-1:0]    longest;
  } stats_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [DATA_W-1:0]     reg_val;
    logic                  act;
    logic [TIME_W-1:0]     ts;
    logic                  typed;
    stats_t                want;
  } step_row_t;

  // Result after reset or level start: nothing counted, no report
  localparam stats_t CLEARED_STATS = '{1'b0, '0, '0, 1'b0, '0, '1, '0};

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic pready;
  logic item_valid, item_stall, action;
  logic [TIME_W-1:0] timestamp;
  logic result_valid, result_stall;
  logic report_valid, low_frame;
  logic [RPT_SUM_W-1:0] report_window_sum;
  logic [CNT_W-1:0] report_frame, frame_total;
  logic [TIME_W-1:0] shortest_period, longest_period;

  // Side channel: typed-in expectation travelling with the offered item
  logic   row_typed;
  stats_t row_want;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  stats_t expected_stats[$];

  // Predictor state: configuration
  logic              en_cfg;
  logic [WSIZE_W-1:0] win_cfg;
  logic [TIME_W-1:0] low_rate_cfg, interval_cfg;
  // Predictor state: frame tracking
  logic [TIME_W-1:0] prev_ts, min_p, max_p, last_rpt_ts;
  logic [CNT_W-1:0]  frame_cnt, held_frm;
  logic              held_ok;
  logic [RPT_SUM_W-1:0] held_sum;
  logic [TIME_W-1:0] period_ring [DEF_MAX_WINDOW];
  int                ring_pos;
  logic [63:0]       win_sum;

  frame_period_moving_average_monitor_unit DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall),
    .action(action), .timestamp(timestamp),
    .result_valid(result_valid), .result_stall(result_stall),
    .report_valid(report_valid), .report_window_sum(report_window_sum),
    .report_frame(report_frame), .low_frame(low_frame),
    .frame_total(frame_total), .shortest_period(shortest_period),
    .longest_period(longest_period)
  );

  always #10 clk = ~clk;

  // Directed items; expectations typed in only for cleared results
  step_row_t directed_rows [30] = '{
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_FRAME,       32'h1234_5678, 1'b1, CLEARED_STATS},
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_LEVEL_START, 32'hFFFF_FFF0, 1'b1, CLEARED_STATS},
    '{ROW_REG,  REG_ENABLE,   32'h1,         ACT_FRAME,       32'h0,         1'b0, CLEARED_STATS},
    '{ROW_REG,  REG_WINDOW,   32'h1,         ACT_FRAME,       32'h0,         1'b0, CLEARED_STATS},
    '{ROW_REG,  REG_LOW_RATE, 32'h0,         ACT_FRAME,       32'h0,         1'b0, CLEARED_STATS},
    '{ROW_REG,  REG_INTERVAL, 32'h0,         ACT_FRAME,       32'h0,         1'b0, CLEARED_STATS},
    // timestamp wraps, then a zero period, then the longest period
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_FRAME,       32'h0000_0010, 1'b0, CLEARED_STATS},
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_FRAME,       32'h0000_0010, 1'b0, CLEARED_STATS},
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_FRAME,       32'h0000_000F, 1'b0, CLEARED_STATS},
    '{ROW_REG,  REG_WINDOW,   32'd64,        ACT_FRAME,       32'h0,         1'b0, CLEARED_STATS},
    '{ROW_REG,  REG_LOW_RATE, 32'hFFFF_FFFF, ACT_FRAME,       32'h0,         1'b0, CLEARED_STATS},
    '{ROW_REG,  REG_INTERVAL, 32'hFFFF_FFFF, ACT_FRAME,       32'h0,         1'b0, CLEARED_STATS},
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_LEVEL_START, 32'h0,         1'b1, CLEARED_STATS},
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_FRAME,       32'hFFFF_FFFF, 1'b0, CLEARED_STATS},
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_FRAME,       32'hFFFF_FFFE, 1'b0, CLEARED_STATS},
    // window above the ring depth acts as full depth
    '{ROW_REG,  REG_WINDOW,   32'd127,       ACT_FRAME,       32'h0,         1'b0, CLEARED_STATS},
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_FRAME,       32'h7FFF_FFFF, 1'b0, CLEARED_STATS},
    // window of zero acts as one
    '{ROW_REG,  REG_WINDOW,   32'd0,         ACT_FRAME,       32'h0,         1'b0, CLEARED_STATS},
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_FRAME,       32'h7FFF_FFFE, 1'b0, CLEARED_STATS},
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_FRAME,       32'h7FFF_FFFD, 1'b0, CLEARED_STATS},
    '{ROW_REG,  REG_INTERVAL, 32'd5,         ACT_FRAME,       32'h0,         1'b0, CLEARED_STATS},
    '{ROW_REG,  REG_LOW_RATE, 32'd3,         ACT_FRAME,       32'h0,         1'b0, CLEARED_STATS},
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_FRAME,       32'h8000_0010, 1'b0, CLEARED_STATS},
    // disabled: frames ignored, level start still clears
    '{ROW_REG,  REG_ENABLE,   32'h0,         ACT_FRAME,       32'h0,         1'b0, CLEARED_STATS},
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_FRAME,       32'h9000_0000, 1'b0, CLEARED_STATS},
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_LEVEL_START, 32'hAAAA_5555, 1'b1, CLEARED_STATS},
    '{ROW_REG,  REG_ENABLE,   32'h1,         ACT_FRAME,       32'h0,         1'b0, CLEARED_STATS},
    '{ROW_REG,  REG_WINDOW,   32'd3,         ACT_FRAME,       32'h0,         1'b0, CLEARED_STATS},
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_FRAME,       32'hAAAA_5558, 1'b0, CLEARED_STATS},
    '{ROW_ITEM, REG_ENABLE,   32'h0,         ACT_FRAME,       32'hAAAA_5560, 1'b0, CLEARED_STATS}
  };

  function automatic void clear_ring();
    foreach (period_ring[i]) period_ring[i] = '0;
    ring_pos = 0;
    win_sum  = '0;
  endfunction

  function automatic void restart_level(logic [TIME_W-1:0] ts);
    clear_ring();
    prev_ts     = ts;
    last_rpt_ts = ts;
    frame_cnt   = '0;
    min_p       = '1;
    max_p       = '0;
    held_ok     = 1'b0;
    held_sum    = '0;
    held_frm    = '0;
  endfunction

  // Frame statistics predicted for one accepted item
  function automatic stats_t monitor_frame_event(logic act, logic [TIME_W-1:0] ts);
    stats_t            r;
    logic [TIME_W-1:0] period, elapsed;
    logic [63:0]       w;
    int                slot;
    r = '0;
    if (act == ACT_LEVEL_START) begin
      restart_level(ts);
    end else if (en_cfg) begin
      w = (win_cfg == 0) ? 64'd1 : (win_cfg > DEF_MAX_WINDOW) ? 64'(DEF_MAX_WINDOW) : 64'(win_cfg);
      period    = ts - prev_ts;
      prev_ts   = ts;
      frame_cnt = frame_cnt + 1'b1;
      if (period > max_p) max_p = period;
      if (period < min_p) min_p = period;
      // report the held frame before this one enters the window
      elapsed = ts - last_rpt_ts;
      if (held_ok && elapsed > interval_cfg) begin
        r.rv        = 1'b1;
        r.rsum      = held_sum;
        r.rframe    = held_frm;
        last_rpt_ts = ts;
        held_ok     = 1'b0;
        held_sum    = '0;
        held_frm    = '0;
      end
      slot = ring_pos;
      if (slot >= w) slot = 0;
      win_sum = win_sum - period_ring[slot] + period;
      period_ring[slot] = period;
      ring_pos = (slot + 1 >= w) ? 0 : slot + 1;
      // low frame: slow average and at least as bad as the held one
      if (win_sum >= w * low_rate_cfg && (!held_ok || period * w >= held_sum)) begin
        held_ok  = 1'b1;
        held_sum = win_sum[RPT_SUM_W-1:0];
        held_frm = frame_cnt;
        r.low    = 1'b1;
      end
    end
    r.total    = frame_cnt;
    r.shortest = min_p;
    r.longest  = max_p;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Scoreboard: predict on input acceptance, check on result acceptance
  always @(posedge clk) begin : scoreboard
    stats_t predicted, want;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        predicted = monitor_frame_event(action, timestamp);
        expected_stats.push_back(row_typed ? row_want : predicted);
      end
      if (result_valid && !result_stall) begin
        if (expected_stats.size() == 0) begin
          $error("result item with no expectation pending");
          mismatches++;
        end else begin
          want = expected_stats.pop_front();
          compare_field("report_valid", want.rv, report_valid);
          compare_field("report_window_sum", want.rsum, report_window_sum);
          compare_field("report_frame", want.rframe, report_frame);
          compare_field("low_frame", want.low, low_frame);
          compare_field("frame_total", want.total, frame_total);
          compare_field("shortest_period", want.shortest, shortest_period);
          compare_field("longest_period", want.longest, longest_period);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        hold_served++;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ENABLE:   en_cfg = val[0];
      REG_WINDOW: begin
        win_cfg = val[WSIZE_W-1:0];
        clear_ring();
      end
      REG_LOW_RATE: low_rate_cfg = val;
      REG_INTERVAL: interval_cfg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic offer_event(input logic act, input logic [TIME_W-1:0] ts,
                             input logic typed, input stats_t want);
    while ($urandom_range(99, 0) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    timestamp  <= ts;
    row_typed  <= typed;
    row_want   <= want;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Stop offering and wait for every expected result
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_stats.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int                 phase, k, pick, n_items;
    int unsigned        base, p;
    logic [TIME_W-1:0]  now_ts;
    logic [WSIZE_W-1:0] win;
    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    item_valid <= 1'b0;
    action     <= ACT_FRAME;
    timestamp  <= '0;
    row_typed  <= 1'b0;
    row_want   <= CLEARED_STATS;
    en_cfg       = RST_ENABLE;
    win_cfg      = RST_WINDOW;
    low_rate_cfg = RST_LOW_RATE;
    interval_cfg = RST_INTERVAL;
    restart_level('0);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        wait_drained();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        offer_event(directed_rows[i].act, directed_rows[i].ts,
                    directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random phases: frame streams near the low-rate threshold
    for (phase = 0; phase < 13; phase++) begin
      wait_drained();
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      base = $urandom_range(50000, 100);
      case ($urandom_range(5, 0))
        0: win = WSIZE_W'($urandom_range(127, 0));
        1: win = WSIZE_W'(DEF_MAX_WINDOW);
        2: win = WSIZE_W'(1);
        default: win = WSIZE_W'($urandom_range(16, 1));
      endcase
      write_reg(REG_WINDOW, DATA_W'(win));
      write_reg(REG_LOW_RATE, base - base / 8 + $urandom_range(base / 4, 0));
      write_reg(REG_INTERVAL, base * $urandom_range(40, 3));
      write_reg(REG_ENABLE, (phase == 6) ? 32'h0 : 32'h1);
      n_items = (phase == 6) ? 40 : 100;
      now_ts = $urandom;
      offer_event(ACT_LEVEL_START, now_ts, 1'b0, CLEARED_STATS);
      for (k = 0; k < n_items; k++) begin
        if (phase == 0 && k == 40) hold_asked++;
        pick = $urandom_range(99, 0);
        if (pick < 3) begin
          now_ts = $urandom;
          offer_event(ACT_LEVEL_START, now_ts, 1'b0, CLEARED_STATS);
        end else if (pick < 6) begin
          // noise: arbitrary timestamp
          now_ts = $urandom;
          offer_event(ACT_FRAME, now_ts, 1'b0, CLEARED_STATS);
        end else begin
          if (pick < 12) p = base * $urandom_range(6, 2);
          else if (pick < 14) p = $urandom_range(3, 0);
          else p = base - base / 4 + $urandom_range(base / 2, 0);
          now_ts = now_ts + p;
          offer_event(ACT_FRAME, now_ts, 1'b0, CLEARED_STATS);
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
